### rtl/lpt_pkg.sv
// shared types, codes and defaults of the multichannel led pattern timer
package lpt_pkg;

    localparam int DEF_CHANNELS = 8;
    localparam int MASK_W       = 8;
    localparam int CHAN_W       = 3;
    localparam int MODE_W       = 3;
    localparam int OP_W         = 2;
    localparam int PERIOD_W     = 16;
    localparam int COUNT_W      = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // pattern modes
    localparam logic [MODE_W-1:0] MODE_OFF        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ON         = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PULSE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ON_TIMED   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FAST_TIMED = 3'd5;

    // operations
    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_MODE  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_TIMED = 2'd2;
    localparam logic [OP_W-1:0] OP_SET_LEVEL = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH  = 3'd4;

    // configuration reset values
    localparam logic [PERIOD_W-1:0] RST_BLINK_PERIOD = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_PULSE_LENGTH = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_FAST_PERIOD  = 16'd100;
    localparam logic [MASK_W-1:0]   RST_ENABLE_MASK  = 8'h00;
    localparam logic [MASK_W-1:0]   RST_ACTIVE_HIGH  = 8'hFF;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_CMD,
        S_WAIT,
        S_RESP
    } t_state;

    // per-channel entry held in the state memory
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [PERIOD_W-1:0] since_change;
        logic [COUNT_W-1:0]  since_start;
        logic [COUNT_W-1:0]  duration;
    } t_chan_state;

    localparam int STATE_W = $bits(t_chan_state);

    // latched command transaction
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [MODE_W-1:0]  new_mode;
        logic [COUNT_W-1:0] duration_ms;
        logic               level;
    } t_cmd;

    // timing registers seen by the update unit
    typedef struct packed {
        logic [PERIOD_W-1:0] blink_period;
        logic [PERIOD_W-1:0] pulse_length;
        logic [PERIOD_W-1:0] fast_period;
    } t_periods;

    // update unit result
    typedef struct packed {
        t_chan_state next;
        logic        state_we;
        logic        lit;
        logic        lit_we;
    } t_upd;

endpackage

### rtl/lpt_ram.sv
// generic single write port, single read port ram with registered read
module lpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lpt_upd.sv
// read-modify-write update of one channel entry for a tick or a command
module lpt_upd (
    input  logic                  i_tick,
    input  lpt_pkg::t_cmd         i_cmd,
    input  lpt_pkg::t_chan_state  i_cur,
    input  logic                  i_lit,
    input  lpt_pkg::t_periods     i_periods,
    output lpt_pkg::t_upd         o_upd
);

    logic [lpt_pkg::PERIOD_W-1:0] sc_inc;
    logic [lpt_pkg::COUNT_W-1:0]  ss_inc;
    logic                         expired;
    logic                         mode_ok;

    // saturating elapsed counters
    assign sc_inc = (i_cur.since_change == '1) ? i_cur.since_change
                                               : i_cur.since_change + 1'b1;
    assign ss_inc = (i_cur.since_start == '1) ? i_cur.since_start
                                              : i_cur.since_start + 1'b1;
    assign expired = (i_cur.duration != '0) && (ss_inc >= i_cur.duration);
    assign mode_ok = (i_cmd.new_mode <= lpt_pkg::MODE_FAST_TIMED);

    // next entry and lit state
    always_comb begin
        o_upd.next     = i_cur;
        o_upd.state_we = 1'b0;
        o_upd.lit      = i_lit;
        o_upd.lit_we   = 1'b0;
        if (i_tick) begin
            o_upd.next.since_change = sc_inc;
            o_upd.next.since_start  = ss_inc;
            o_upd.state_we          = 1'b1;
            case (i_cur.mode)
                lpt_pkg::MODE_BLINK: begin
                    if (sc_inc >= i_periods.blink_period) begin
                        o_upd.next.since_change = '0;
                        o_upd.lit               = ~i_lit;
                        o_upd.lit_we            = 1'b1;
                    end
                end
                lpt_pkg::MODE_PULSE: begin
                    if (sc_inc >= i_periods.pulse_length) begin
                        o_upd.next.mode         = lpt_pkg::MODE_OFF;
                        o_upd.next.since_change = '0;
                        o_upd.lit               = 1'b0;
                        o_upd.lit_we            = 1'b1;
                    end
                end
                lpt_pkg::MODE_ON_TIMED: begin
                    if (expired) begin
                        o_upd.next.mode         = lpt_pkg::MODE_OFF;
                        o_upd.next.since_change = '0;
                        o_upd.lit               = 1'b0;
                        o_upd.lit_we            = 1'b1;
                    end
                end
                lpt_pkg::MODE_FAST_TIMED: begin
                    if (expired) begin
                        o_upd.next.mode         = lpt_pkg::MODE_OFF;
                        o_upd.next.since_change = '0;
                        o_upd.lit               = 1'b0;
                        o_upd.lit_we            = 1'b1;
                    end else if (sc_inc >= i_periods.fast_period) begin
                        o_upd.next.since_change = '0;
                        o_upd.lit               = ~i_lit;
                        o_upd.lit_we            = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (i_cmd.op)
                lpt_pkg::OP_SET_MODE: begin
                    if (mode_ok && (i_cur.mode != i_cmd.new_mode)) begin
                        o_upd.next.mode         = i_cmd.new_mode;
                        o_upd.next.since_change = '0;
                        o_upd.next.since_start  = '0;
                        o_upd.next.duration     = '0;
                        o_upd.state_we          = 1'b1;
                        o_upd.lit               = (i_cmd.new_mode != lpt_pkg::MODE_OFF);
                        o_upd.lit_we            = 1'b1;
                    end
                end
                lpt_pkg::OP_SET_TIMED: begin
                    if (mode_ok) begin
                        o_upd.next.mode         = i_cmd.new_mode;
                        o_upd.next.since_change = '0;
                        o_upd.next.since_start  = '0;
                        o_upd.next.duration     = i_cmd.duration_ms;
                        o_upd.state_we          = 1'b1;
                        o_upd.lit               = i_cmd.new_mode inside
                            {lpt_pkg::MODE_ON_TIMED, lpt_pkg::MODE_FAST_TIMED};
                        o_upd.lit_we            = 1'b1;
                    end
                end
                lpt_pkg::OP_SET_LEVEL: begin
                    o_upd.lit    = i_cmd.level;
                    o_upd.lit_we = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/multichannel_led_pattern_timer.sv
// top level of the multichannel led pattern timer: sequencer, state memory, outputs
//
// Usage: a transaction is accepted when i_start is high and o_busy is low; it
// carries i_op (tick, set mode, set timed mode, set level), i_channel,
// i_new_mode, i_duration_ms and i_level. Every transaction gives exactly one
// result, shown for one cycle with o_valid high: o_pin_levels, o_lit_states
// and o_channel_mode of the addressed channel. The receiver cannot stall.
// Configuration goes over the i_cfg_valid / o_cfg_ready channel (always
// ready) with i_cfg_index and i_cfg_data; the user must write it only while
// idle, as the block itself does not enforce this. Per-channel mode, counters
// and duration sit in one memory with a registered read; the lit states sit
// in flip-flops. Timing: a tick sweeps the memory one channel per cycle, reads
// overlapping the trailing write back, then waits for the last write and shows
// its result; a command reads, updates and writes its one channel, then shows
// its result. A new transaction can be accepted in the cycle that shows the
// result.
// Reset: synchronous i_rst_n clears configuration to defaults and marks every
// memory entry invalid, which reads as off with counters zero; no clearing
// pass is needed. Enabling a channel clears it the same way.
module multichannel_led_pattern_timer #(
    parameter int CHANNELS = lpt_pkg::DEF_CHANNELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [lpt_pkg::OP_W-1:0]          i_op,
    input  logic [lpt_pkg::CHAN_W-1:0]        i_channel,
    input  logic [lpt_pkg::MODE_W-1:0]        i_new_mode,
    input  logic [lpt_pkg::COUNT_W-1:0]       i_duration_ms,
    input  logic                              i_level,
    output logic                              o_valid,
    output logic [lpt_pkg::MASK_W-1:0]        o_pin_levels,
    output logic [lpt_pkg::MASK_W-1:0]        o_lit_states,
    output logic [lpt_pkg::MODE_W-1:0]        o_channel_mode,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    lpt_pkg::t_state r_state, n_state;

    logic [AW-1:0]                   r_idx, n_idx;
    logic                            r_pend, n_pend;
    logic [AW-1:0]                   r_pend_idx, n_pend_idx;
    logic                            r_is_tick;
    logic                            r_target;
    logic [lpt_pkg::CHAN_W-1:0]      r_chn;
    lpt_pkg::t_cmd                   r_cmd;
    logic [lpt_pkg::MODE_W-1:0]      r_cmode;

    logic [lpt_pkg::PERIOD_W-1:0]    r_blink_period;
    logic [lpt_pkg::PERIOD_W-1:0]    r_pulse_length;
    logic [lpt_pkg::PERIOD_W-1:0]    r_fast_period;
    logic [lpt_pkg::MASK_W-1:0]      r_enable;
    logic [lpt_pkg::MASK_W-1:0]      r_active_high;

    logic [CHANNELS-1:0]             r_valid;
    logic [CHANNELS-1:0]             r_lit;

    logic                            accept;
    logic                            cfg_wr;
    logic                            target_in;
    logic [lpt_pkg::MASK_W-1:0]      en_rise;
    logic [AW-1:0]                   ram_raddr;
    logic [lpt_pkg::STATE_W-1:0]     ram_rdata;
    logic                            ram_we;
    lpt_pkg::t_chan_state            cur;
    lpt_pkg::t_periods               periods;
    lpt_pkg::t_upd                   upd;
    logic                            pend_gate;
    logic                            pend_is_target;

    // enable bit of a swept channel; channels past the mask width count as disabled
    function automatic logic chan_enabled(input logic [AW-1:0] idx,
                                          input logic [lpt_pkg::MASK_W-1:0] en);
        logic [31:0] w;
        w = 32'(idx);
        return (w < 32'(lpt_pkg::MASK_W)) && en[w[2:0]];
    endfunction

    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign target_in   = (32'(i_channel) < 32'(CHANNELS)) && r_enable[i_channel];
    assign en_rise     = i_cfg_data[lpt_pkg::MASK_W-1:0] & ~r_enable;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_period <= lpt_pkg::RST_BLINK_PERIOD;
            r_pulse_length <= lpt_pkg::RST_PULSE_LENGTH;
            r_fast_period  <= lpt_pkg::RST_FAST_PERIOD;
            r_enable       <= lpt_pkg::RST_ENABLE_MASK;
            r_active_high  <= lpt_pkg::RST_ACTIVE_HIGH;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                lpt_pkg::CFG_BLINK_PERIOD: r_blink_period <= i_cfg_data;
                lpt_pkg::CFG_PULSE_LENGTH: r_pulse_length <= i_cfg_data;
                lpt_pkg::CFG_FAST_PERIOD:  r_fast_period  <= i_cfg_data;
                lpt_pkg::CFG_ENABLE_MASK:
                    r_enable <= i_cfg_data[lpt_pkg::MASK_W-1:0];
                lpt_pkg::CFG_ACTIVE_HIGH:
                    r_active_high <= i_cfg_data[lpt_pkg::MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpt_pkg::S_IDLE, lpt_pkg::S_RESP: begin
                if (i_start) begin
                    n_state = (i_op == lpt_pkg::OP_TICK) ? lpt_pkg::S_SWEEP
                                                        : lpt_pkg::S_CMD;
                end else begin
                    n_state = lpt_pkg::S_IDLE;
                end
            end
            lpt_pkg::S_SWEEP: begin
                if (r_idx == AW'(CHANNELS - 1)) begin
                    n_state = lpt_pkg::S_WAIT;
                end
            end
            lpt_pkg::S_CMD:  n_state = lpt_pkg::S_WAIT;
            lpt_pkg::S_WAIT: n_state = lpt_pkg::S_RESP;
            default:         n_state = lpt_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: memory read issue and sweep counter
    always_comb begin
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        ram_raddr  = r_idx;
        case (r_state)
            lpt_pkg::S_SWEEP: begin
                ram_raddr  = r_idx;
                n_pend     = 1'b1;
                n_pend_idx = r_idx;
                n_idx      = r_idx + 1'b1;
            end
            lpt_pkg::S_CMD: begin
                ram_raddr  = r_target ? AW'(r_chn) : '0;
                n_pend     = 1'b1;
                n_pend_idx = ram_raddr;
            end
            lpt_pkg::S_IDLE, lpt_pkg::S_RESP: begin
                n_idx = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_busy  = !((r_state == lpt_pkg::S_IDLE) || (r_state == lpt_pkg::S_RESP));
    assign o_valid = (r_state == lpt_pkg::S_RESP);

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpt_pkg::S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
    end

    // latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_tick         <= (i_op == lpt_pkg::OP_TICK);
            r_target          <= target_in;
            r_chn             <= i_channel;
            r_cmd.op          <= i_op;
            r_cmd.new_mode    <= i_new_mode;
            r_cmd.duration_ms <= i_duration_ms;
            r_cmd.level       <= i_level;
        end
    end

    // state memory
    lpt_ram #(
        .WIDTH (lpt_pkg::STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pend_idx),
        .i_wdata (upd.next),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // never-written or freshly enabled entries read as cleared
    assign cur = r_valid[r_pend_idx] ? lpt_pkg::t_chan_state'(ram_rdata) : '0;

    assign periods.blink_period = r_blink_period;
    assign periods.pulse_length = r_pulse_length;
    assign periods.fast_period  = r_fast_period;

    lpt_upd u_upd (
        .i_tick    (r_is_tick),
        .i_cmd     (r_cmd),
        .i_cur     (cur),
        .i_lit     (r_lit[r_pend_idx]),
        .i_periods (periods),
        .o_upd     (upd)
    );

    // ticks touch enabled channels only, commands only a valid target
    assign pend_gate = r_pend && (r_is_tick ? chan_enabled(r_pend_idx, r_enable) : r_target);
    assign ram_we    = pend_gate && upd.state_we;
    assign pend_is_target = pend_gate && r_target && (32'(r_pend_idx) == 32'(r_chn));

    // valid bits and lit states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_lit   <= '0;
        end else begin
            if (ram_we) begin
                r_valid[r_pend_idx] <= 1'b1;
            end
            if (pend_gate && upd.lit_we) begin
                r_lit[r_pend_idx] <= upd.lit;
            end
            if (cfg_wr && (i_cfg_index == lpt_pkg::CFG_ENABLE_MASK)) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (i < lpt_pkg::MASK_W) begin
                        if (en_rise[i]) begin
                            r_valid[i] <= 1'b0;
                            r_lit[i]   <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    // mode of the addressed channel, captured as it passes the update unit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmode <= lpt_pkg::MODE_OFF;
        end else if (pend_is_target) begin
            r_cmode <= upd.state_we ? upd.next.mode : cur.mode;
        end
    end

    // pin and lit vectors
    for (genvar g = 0; g < lpt_pkg::MASK_W; g++) begin : g_out
        if (g < CHANNELS) begin : g_live
            assign o_lit_states[g] = r_enable[g] && r_lit[g];
            assign o_pin_levels[g] = r_enable[g] && (r_lit[g] == r_active_high[g]);
        end else begin : g_none
            assign o_lit_states[g] = 1'b0;
            assign o_pin_levels[g] = 1'b0;
        end
    end

    assign o_channel_mode = r_target ? r_cmode : lpt_pkg::MODE_OFF;

`ifndef SYNTH
    // a memory write only ever completes a read issued the cycle before
    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> $past(n_pend))
        else $error("state memory written without a pending read");

    // during a sweep the trailing write never hits the entry being read
    a_sweep_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == lpt_pkg::S_SWEEP)) |-> (r_pend_idx != ram_raddr))
        else $error("sweep write and read collide");

    // a result is shown only right after the last update
    a_result_after_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == lpt_pkg::S_WAIT))
        else $error("result without a finished update");

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("accepted transaction did not start");

    // an unaddressable channel always reads as off
    a_no_target_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_target) |-> (o_channel_mode == lpt_pkg::MODE_OFF))
        else $error("mode reported for a disabled channel");
`endif

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the multichannel led pattern timer
`timescale 1ns / 1ps

module testbench;

    localparam int NCH          = lpt_pkg::DEF_CHANNELS;
    localparam int CH_W         = lpt_pkg::CHAN_W;
    localparam int MD_W         = lpt_pkg::MODE_W;
    localparam int MK_W         = lpt_pkg::MASK_W;
    localparam int DT_W         = lpt_pkg::CFG_DATA_W;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int DRAIN_CYCLES = NCH + 12;
    localparam int CYCLE_LIMIT  = 300000;

    // one command transaction
    typedef struct {
        logic [lpt_pkg::OP_W-1:0]    op;
        logic [lpt_pkg::CHAN_W-1:0]  channel;
        logic [lpt_pkg::MODE_W-1:0]  new_mode;
        logic [lpt_pkg::COUNT_W-1:0] duration;
        logic                        level;
    } t_led_item;

    // one result transaction
    typedef struct {
        logic [lpt_pkg::MASK_W-1:0] pins;
        logic [lpt_pkg::MASK_W-1:0] lits;
        logic [lpt_pkg::MODE_W-1:0] mode;
    } t_led_view;

    // tracks channel patterns and holds the outputs each transaction should give
    class pattern_scoreboard;
        bit [lpt_pkg::PERIOD_W-1:0] blink_period = lpt_pkg::RST_BLINK_PERIOD;
        bit [lpt_pkg::PERIOD_W-1:0] pulse_length = lpt_pkg::RST_PULSE_LENGTH;
        bit [lpt_pkg::PERIOD_W-1:0] fast_period  = lpt_pkg::RST_FAST_PERIOD;
        bit [lpt_pkg::MASK_W-1:0]   enable_mask  = lpt_pkg::RST_ENABLE_MASK;
        bit [lpt_pkg::MASK_W-1:0]   active_high  = lpt_pkg::RST_ACTIVE_HIGH;

        bit [lpt_pkg::MODE_W-1:0]   mode_q       [NCH];
        bit                         lit_q        [NCH];
        bit [lpt_pkg::PERIOD_W-1:0] since_change [NCH];
        bit [lpt_pkg::COUNT_W-1:0]  since_start  [NCH];
        bit [lpt_pkg::COUNT_W-1:0]  duration_q   [NCH];

        t_led_view expected_outputs[$];
        int        errors = 0;

        function int pending();
            return expected_outputs.size();
        endfunction

        function void clear_channel(int i);
            mode_q[i]       = lpt_pkg::MODE_OFF;
            lit_q[i]        = 1'b0;
            since_change[i] = '0;
            since_start[i]  = '0;
            duration_q[i]   = '0;
        endfunction

        function void switch_off(int i);
            lit_q[i]        = 1'b0;
            mode_q[i]       = lpt_pkg::MODE_OFF;
            since_change[i] = '0;
        endfunction

        function void flip(int i);
            lit_q[i]        = !lit_q[i];
            since_change[i] = '0;
        endfunction

        // one millisecond on one channel, counters saturate
        function void tick_one_channel(int i);
            bit expired;
            if (since_change[i] != '1) since_change[i] = since_change[i] + 1'b1;
            if (since_start[i] != '1) since_start[i] = since_start[i] + 1'b1;
            expired = (duration_q[i] != 0) && (since_start[i] >= duration_q[i]);
            case (mode_q[i])
                lpt_pkg::MODE_BLINK: if (since_change[i] >= blink_period) flip(i);
                lpt_pkg::MODE_PULSE: if (since_change[i] >= pulse_length) switch_off(i);
                lpt_pkg::MODE_ON_TIMED: if (expired) switch_off(i);
                lpt_pkg::MODE_FAST_TIMED: begin
                    if (expired) switch_off(i);
                    else if (since_change[i] >= fast_period) flip(i);
                end
                default: ;
            endcase
        endfunction

        function void write_reg(logic [lpt_pkg::CFG_IDX_W-1:0] idx,
                                logic [lpt_pkg::CFG_DATA_W-1:0] data);
            bit [lpt_pkg::MASK_W-1:0] rising;
            case (idx)
                lpt_pkg::CFG_BLINK_PERIOD: blink_period = data;
                lpt_pkg::CFG_PULSE_LENGTH: pulse_length = data;
                lpt_pkg::CFG_FAST_PERIOD:  fast_period  = data;
                lpt_pkg::CFG_ENABLE_MASK: begin
                    rising      = data[lpt_pkg::MASK_W-1:0] & ~enable_mask;
                    enable_mask = data[lpt_pkg::MASK_W-1:0];
                    for (int i = 0; i < NCH; i++)
                        if (rising[i]) clear_channel(i);
                end
                lpt_pkg::CFG_ACTIVE_HIGH:  active_high = data[lpt_pkg::MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // apply an accepted transaction and queue the outputs it should produce
        function void note_command(t_led_item it);
            t_led_view want;
            bit        hit;
            int        ch;
            ch  = int'(it.channel);
            hit = enable_mask[ch];
            if (it.op == lpt_pkg::OP_TICK) begin
                for (int i = 0; i < NCH; i++)
                    if (enable_mask[i]) tick_one_channel(i);
            end else if (hit) begin
                case (it.op)
                    lpt_pkg::OP_SET_MODE: begin
                        if (it.new_mode <= lpt_pkg::MODE_FAST_TIMED &&
                            mode_q[ch] != it.new_mode) begin
                            mode_q[ch]       = it.new_mode;
                            since_change[ch] = '0;
                            since_start[ch]  = '0;
                            duration_q[ch]   = '0;
                            lit_q[ch]        = (it.new_mode != lpt_pkg::MODE_OFF);
                        end
                    end
                    lpt_pkg::OP_SET_TIMED: begin
                        if (it.new_mode <= lpt_pkg::MODE_FAST_TIMED) begin
                            mode_q[ch]       = it.new_mode;
                            duration_q[ch]   = it.duration;
                            since_start[ch]  = '0;
                            since_change[ch] = '0;
                            lit_q[ch]        = (it.new_mode == lpt_pkg::MODE_ON_TIMED) ||
                                               (it.new_mode == lpt_pkg::MODE_FAST_TIMED);
                        end
                    end
                    default: lit_q[ch] = it.level;
                endcase
            end
            want.pins = '0;
            want.lits = '0;
            want.mode = lpt_pkg::MODE_OFF;
            for (int i = 0; i < NCH; i++) begin
                if (enable_mask[i]) begin
                    want.lits[i] = lit_q[i];
                    want.pins[i] = (lit_q[i] == active_high[i]);
                end
            end
            if (hit) want.mode = mode_q[ch];
            expected_outputs.push_back(want);
        endfunction

        function void check_outputs(logic [lpt_pkg::MASK_W-1:0] pins,
                                    logic [lpt_pkg::MASK_W-1:0] lits,
                                    logic [lpt_pkg::MODE_W-1:0] mode);
            t_led_view want;
            if (expected_outputs.size() == 0) begin
                $error("result with no transaction outstanding: pins %h lits %h mode %0d",
                       pins, lits, mode);
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            if (pins !== want.pins) begin
                $error("pin_levels: expected %h, actual %h", want.pins, pins);
                errors++;
            end
            if (lits !== want.lits) begin
                $error("lit_states: expected %h, actual %h", want.lits, lits);
                errors++;
            end
            if (mode !== want.mode) begin
                $error("channel_mode: expected %0d, actual %0d", want.mode, mode);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_start       = 1'b0;
    logic [lpt_pkg::OP_W-1:0]         i_op          = lpt_pkg::OP_TICK;
    logic [lpt_pkg::CHAN_W-1:0]       i_channel     = '0;
    logic [lpt_pkg::MODE_W-1:0]       i_new_mode    = lpt_pkg::MODE_OFF;
    logic [lpt_pkg::COUNT_W-1:0]      i_duration_ms = '0;
    logic                             i_level       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic [lpt_pkg::CFG_IDX_W-1:0]    i_cfg_index   = lpt_pkg::CFG_BLINK_PERIOD;
    logic [lpt_pkg::CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                             o_busy;
    logic                             o_valid;
    logic [lpt_pkg::MASK_W-1:0]       o_pin_levels;
    logic [lpt_pkg::MASK_W-1:0]       o_lit_states;
    logic [lpt_pkg::MODE_W-1:0]       o_channel_mode;
    logic                             o_cfg_ready;

    pattern_scoreboard sb = new;
    int unsigned       cycle_count = 0;

    multichannel_led_pattern_timer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_op           (i_op),
        .i_channel      (i_channel),
        .i_new_mode     (i_new_mode),
        .i_duration_ms  (i_duration_ms),
        .i_level        (i_level),
        .o_valid        (o_valid),
        .o_pin_levels   (o_pin_levels),
        .o_lit_states   (o_lit_states),
        .o_channel_mode (o_channel_mode),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_outputs(o_pin_levels, o_lit_states, o_channel_mode);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one transaction after a gap and wait until it is taken
    task automatic send_item(input t_led_item it, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_op          <= it.op;
        i_channel     <= it.channel;
        i_new_mode    <= it.new_mode;
        i_duration_ms <= it.duration;
        i_level       <= it.level;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_command(it);
    endtask

    // hold off until every expected result has come and the block is free
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 || o_busy) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [lpt_pkg::CFG_DATA_W-1:0] blink,
                                   input logic [lpt_pkg::CFG_DATA_W-1:0] pulse,
                                   input logic [lpt_pkg::CFG_DATA_W-1:0] fast,
                                   input logic [lpt_pkg::MASK_W-1:0] enable,
                                   input logic [lpt_pkg::MASK_W-1:0] active);
        logic [lpt_pkg::CFG_DATA_W-1:0] data [5];
        logic [lpt_pkg::CFG_IDX_W-1:0]  idx  [5];
        idx[0] = lpt_pkg::CFG_BLINK_PERIOD;  data[0] = blink;
        idx[1] = lpt_pkg::CFG_PULSE_LENGTH;  data[1] = pulse;
        idx[2] = lpt_pkg::CFG_FAST_PERIOD;   data[2] = fast;
        idx[3] = lpt_pkg::CFG_ENABLE_MASK;   data[3] = {{(DT_W-MK_W){1'b0}}, enable};
        idx[4] = lpt_pkg::CFG_ACTIVE_HIGH;   data[4] = {{(DT_W-MK_W){1'b0}}, active};
        for (int k = 0; k < 5; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(idx[k], data[k]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_led_item make_item(logic [lpt_pkg::OP_W-1:0] op, int ch,
                                            logic [lpt_pkg::MODE_W-1:0] md,
                                            logic [lpt_pkg::COUNT_W-1:0] dur, logic lvl);
        t_led_item it;
        it.op       = op;
        it.channel  = CH_W'(ch);
        it.new_mode = md;
        it.duration = dur;
        it.level    = lvl;
        return it;
    endfunction

    // mostly short periods so patterns turn over often
    function automatic logic [lpt_pkg::CFG_DATA_W-1:0] pick_period();
        if ($urandom_range(0, 7) == 0) return DT_W'($urandom_range(1, 65535));
        return DT_W'($urandom_range(1, 12));
    endfunction

    function automatic logic [lpt_pkg::COUNT_W-1:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(1, 30);
        if (r < 7) return '0;
        if (r < 9) return $urandom;
        return '1;
    endfunction

    function automatic t_led_item random_item();
        t_led_item   it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)      it.op = lpt_pkg::OP_TICK;
        else if (r < 67) it.op = lpt_pkg::OP_SET_MODE;
        else if (r < 84) it.op = lpt_pkg::OP_SET_TIMED;
        else             it.op = lpt_pkg::OP_SET_LEVEL;
        it.channel  = CH_W'($urandom_range(0, NCH - 1));
        if ($urandom_range(0, 39) == 0) it.new_mode = MD_W'($urandom_range(6, 7));
        else                            it.new_mode = MD_W'($urandom_range(0, 5));
        it.duration = pick_duration();
        it.level    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // stimulus
    initial begin
        t_led_item directed[$];
        t_led_item it;
        int        counted;
        bit        no_gap;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: every channel disabled, so commands are dropped
        send_item(make_item(lpt_pkg::OP_TICK, 0, lpt_pkg::MODE_OFF, '0, 1'b0), 0);
        send_item(make_item(lpt_pkg::OP_SET_MODE, 0, lpt_pkg::MODE_ON, '0, 1'b0), 1);
        wait_idle();

        // zero blink period toggles on every tick, mixed polarity
        write_registers(16'd0, 16'd1, 16'd2, 8'hFF, 8'h5A);
        directed.push_back(make_item(lpt_pkg::OP_SET_MODE, 0, lpt_pkg::MODE_ON, '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_MODE, 0, lpt_pkg::MODE_ON, '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_MODE, 1, lpt_pkg::MODE_BLINK, '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_MODE, 2, lpt_pkg::MODE_PULSE, '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_MODE, 3, lpt_pkg::MODE_ON_TIMED,
                                     '1, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_TIMED, 4, lpt_pkg::MODE_FAST_TIMED,
                                     32'd3, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_TIMED, 5, lpt_pkg::MODE_ON_TIMED,
                                     '1, 1'b1));
        directed.push_back(make_item(lpt_pkg::OP_SET_TIMED, 6, lpt_pkg::MODE_BLINK,
                                     32'd2, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_MODE, 7, 3'd6, '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_TIMED, 7, 3'd7, 32'd5, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_LEVEL, 7, lpt_pkg::MODE_OFF, '0, 1'b1));
        repeat (4)
            directed.push_back(make_item(lpt_pkg::OP_TICK, 0, lpt_pkg::MODE_OFF, '0, 1'b0));
        // same timed mode again is taken, zero duration never expires
        directed.push_back(make_item(lpt_pkg::OP_SET_TIMED, 4, lpt_pkg::MODE_FAST_TIMED,
                                     '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_LEVEL, 0, lpt_pkg::MODE_OFF, '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_MODE, 5, lpt_pkg::MODE_OFF, '0, 1'b0));
        directed.push_back(make_item(lpt_pkg::OP_SET_TIMED, 3, lpt_pkg::MODE_PULSE,
                                     '0, 1'b1));
        directed.push_back(make_item(lpt_pkg::OP_SET_TIMED, 2, lpt_pkg::MODE_OFF,
                                     32'd1, 1'b0));
        repeat (2)
            directed.push_back(make_item(lpt_pkg::OP_TICK, 7, lpt_pkg::MODE_BLINK,
                                         '1, 1'b1));
        foreach (directed[k]) send_item(directed[k], $urandom_range(0, 4));

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: write_registers(16'd1, 16'd1, 16'd1, 8'hFF, 8'h00);
                1: write_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                default: write_registers(pick_period(), pick_period(), pick_period(),
                                         ($urandom_range(0, 5) == 0) ? 8'hFF
                                             : MK_W'($urandom_range(1, 255)),
                                         MK_W'($urandom_range(0, 255)));
            endcase
            no_gap  = (phase == 0) || ($urandom_range(0, 3) == 0);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if ($urandom_range(0, 79) == 0) wait_idle();
                it = random_item();
                counted++;
                send_item(it, no_gap ? 0 : $urandom_range(0, 4));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
